// ----- design/hdlf_pkg.sv -----
// ----------------------------------------------------------------------------
// hdlf_pkg
// Types, constants and helper functions for the hex dump line formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package hdlf_pkg;

  localparam int BYTES_PER_LINE = 16;
  localparam int ADDR_W         = 40;
  localparam int DEC_DIGITS     = 11;
  localparam int DEC_W          = 4 * DEC_DIGITS;
  localparam int HEX_DIGITS     = ADDR_W / 4;
  localparam int FULL_DIGITS    = 13;
  localparam int FULL_BCD_W     = 4 * FULL_DIGITS;
  localparam int CONV_BITS      = 4;
  localparam int CONV_STEPS     = ADDR_W / CONV_BITS;
  localparam int CONV_CNT_W     = $clog2(CONV_STEPS);
  localparam int LINE_WORDS     = 11;
  localparam int LINE_BUF_BYTES = 8 * LINE_WORDS;
  localparam int LEN_W          = 7;
  localparam int WIDX_W         = $clog2(LINE_WORDS);

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BAR      = 8'h7C;
  localparam logic [7:0] CH_NEWLINE  = 8'h0A;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_HEX_UPPER     = 1'b1;

  typedef struct packed {
    logic [63:0] bytes_low;
    logic [63:0] bytes_high;
    logic [4:0]  byte_count;
    logic        first_line;
  } in_t;

  typedef struct packed {
    logic [63:0] text_chars;
    logic [3:0]  char_count;
    logic        line_end;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'h0, nib};
    end else begin
      c = (upper ? 8'h37 : 8'h57) + {4'h0, nib};
    end
    return c;
  endfunction

  function automatic logic [7:0] shown_char(input logic [7:0] b);
    return (b >= CH_SPACE && b <= CH_TILDE) ? b : CH_DOT;
  endfunction

  // Adds 16 to an eleven digit BCD value, dropping the carry out.
  function automatic logic [DEC_W-1:0] bcd_add16(input logic [DEC_W-1:0] v);
    logic [DEC_W-1:0] r;
    logic [4:0]       d;
    logic             c;
    r = '0;
    c = 1'b0;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      d = {1'b0, v[4*k +: 4]} + {4'h0, c};
      if (k == 0) d = d + 5'd6;
      if (k == 1) d = d + 5'd1;
      if (d >= 5'd10) begin
        d = d - 5'd10;
        c = 1'b1;
      end else begin
        c = 1'b0;
      end
      r[4*k +: 4] = d[3:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/hex_dump_line_formatter.sv -----
// ----------------------------------------------------------------------------
// hex_dump_line_formatter
// Formats 16-byte blocks into hex dump text lines, eight characters a word.
// ----------------------------------------------------------------------------
// Each accepted block becomes one text line of 65 + n characters (n bytes,
// 0..16), sent as 9 to 11 result words of up to eight characters, one word
// per cycle while out_stall is low. A block waits in an input register
// while the previous line drains, so the next block is taken while results
// are still going out. A block with first_line set also waits for the
// decimal form of start_address, which a shift-and-add-3 converter works
// out after the block is taken. Later lines step the address by 16 in
// binary and BCD together, so they need no conversion.
`default_nettype none

module hex_dump_line_formatter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire hdlf_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output hdlf_pkg::out_t                     out_data,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [hdlf_pkg::ADDR_W-1:0]   cfg_wdata
);

  logic [hdlf_pkg::ADDR_W-1:0] start_addr_r;
  logic                        hex_upper_r;

  logic                        a_valid_r, a_valid_nxt;
  hdlf_pkg::in_t               a_data_r;
  logic                        a_move;
  logic                        in_accept;

  logic [hdlf_pkg::ADDR_W-1:0] line_addr_r, line_addr_nxt;
  logic [hdlf_pkg::DEC_W-1:0]  dec_addr_r,  dec_addr_nxt;
  logic [hdlf_pkg::ADDR_W-1:0] addr_use;
  logic [hdlf_pkg::DEC_W-1:0]  dec_use;
  logic [hdlf_pkg::ADDR_W:0]   addr_sum;

  hdlf_pkg::conv_status_t      conv_st;
  logic [hdlf_pkg::DEC_W-1:0]  conv_bcd;
  logic                        conv_start;

  logic [hdlf_pkg::LINE_BUF_BYTES-1:0][7:0] fmt_line;
  logic [hdlf_pkg::LEN_W-1:0]               fmt_len;

  logic                                     b_valid_r, b_valid_nxt;
  logic [hdlf_pkg::LINE_WORDS-1:0][63:0]    line_r,    line_nxt;
  logic [hdlf_pkg::LEN_W-1:0]               rem_r,     rem_nxt;
  logic [hdlf_pkg::WIDX_W-1:0]              widx_r,    widx_nxt;
  logic                                     b_last;
  logic                                     b_free;

  logic                                     out_load;
  logic                                     out_valid_r, out_valid_nxt;
  hdlf_pkg::out_t                           out_data_r,  out_data_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= '0;
      hex_upper_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hdlf_pkg::REG_START_ADDRESS: start_addr_r <= cfg_wdata;
        hdlf_pkg::REG_HEX_UPPER:     hex_upper_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input stage
  assign b_last    = (rem_r <= 7'd8);
  assign out_load  = b_valid_r && (!out_valid_r || !out_stall);
  assign b_free    = !b_valid_r || (out_load && b_last);
  assign a_move    = a_valid_r && b_free && (!a_data_r.first_line || conv_st.done);
  assign in_stall  = a_valid_r && !a_move;
  assign in_accept = in_valid && !in_stall;
  assign conv_start = a_valid_r && a_data_r.first_line && !conv_st.busy && !conv_st.done;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_accept)   a_valid_nxt = 1'b1;
    else if (a_move) a_valid_nxt = 1'b0;
  end

  hdlf_bcd_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .clear  (a_move),
    .bin    (start_addr_r),
    .status (conv_st),
    .bcd    (conv_bcd)
  );

  // line address tracking
  assign addr_use = a_data_r.first_line ? start_addr_r : line_addr_r;
  assign dec_use  = a_data_r.first_line ? conv_bcd : dec_addr_r;
  assign addr_sum = {1'b0, addr_use} + (hdlf_pkg::ADDR_W+1)'(hdlf_pkg::BYTES_PER_LINE);

  // on a wrap the new address is below 16, so its decimal form has at most two digits
  always_comb begin
    line_addr_nxt = line_addr_r;
    dec_addr_nxt  = dec_addr_r;
    if (a_move) begin
      line_addr_nxt = addr_sum[hdlf_pkg::ADDR_W-1:0];
      if (addr_sum[hdlf_pkg::ADDR_W]) begin
        dec_addr_nxt = '0;
        if (addr_sum[3:0] >= 4'd10) begin
          dec_addr_nxt[7:0] = {4'd1, addr_sum[3:0] - 4'd10};
        end else begin
          dec_addr_nxt[3:0] = addr_sum[3:0];
        end
      end else begin
        dec_addr_nxt = hdlf_pkg::bcd_add16(dec_use);
      end
    end
  end

  hdlf_line_fmt u_fmt (
    .item      (a_data_r),
    .addr      (addr_use),
    .dec       (dec_use),
    .hex_upper (hex_upper_r),
    .line      (fmt_line),
    .len       (fmt_len)
  );

  // line buffer
  always_comb begin
    b_valid_nxt = b_valid_r;
    line_nxt    = line_r;
    rem_nxt     = rem_r;
    widx_nxt    = widx_r;
    if (a_move) begin
      b_valid_nxt = 1'b1;
      line_nxt    = fmt_line;
      rem_nxt     = fmt_len;
      widx_nxt    = '0;
    end else if (out_load) begin
      if (b_last) begin
        b_valid_nxt = 1'b0;
      end else begin
        rem_nxt  = rem_r - 7'd8;
        widx_nxt = widx_r + 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.text_chars = line_r[widx_r];
      out_data_nxt.char_count = b_last ? rem_r[3:0] : 4'd8;
      out_data_nxt.line_end   = b_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      line_addr_r <= '0;
      dec_addr_r  <= '0;
      rem_r       <= '0;
      widx_r      <= '0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      line_addr_r <= line_addr_nxt;
      dec_addr_r  <= dec_addr_nxt;
      rem_r       <= rem_nxt;
      widx_r      <= widx_nxt;
    end
    if (in_accept) a_data_r <= in_data;
    line_r     <= line_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_first_needs_conv: assert property (@(posedge clk) disable iff (!rst_n)
    a_move && a_data_r.first_line |-> conv_st.done)
    else $error("first line left input stage before decimal conversion finished");

  a_conv_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
    conv_st.busy |-> a_valid_r && a_data_r.first_line)
    else $error("converter running without a pending first line");

  a_line_start_len: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && widx_r == '0 |-> rem_r >= 7'd65 && rem_r <= 7'd81)
    else $error("line length out of range at start of line");

  a_last_word_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && b_last |=> !b_valid_r || widx_r == '0)
    else $error("line buffer kept emitting past the last word");

endmodule

`default_nettype wire

// ----- design/hdlf_bcd_conv.sv -----
// ----------------------------------------------------------------------------
// hdlf_bcd_conv
// Binary to BCD converter, shift-and-add-3, four bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlf_bcd_conv (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            clear,
  input  wire logic [hdlf_pkg::ADDR_W-1:0]     bin,
  output hdlf_pkg::conv_status_t               status,
  output logic      [hdlf_pkg::DEC_W-1:0]      bcd
);

  logic [hdlf_pkg::ADDR_W-1:0]     bin_r,  bin_nxt;
  logic [hdlf_pkg::FULL_BCD_W-1:0] acc_r,  acc_nxt;
  logic [hdlf_pkg::CONV_CNT_W-1:0] cnt_r,  cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [hdlf_pkg::FULL_BCD_W-1:0] step;

  always_comb begin
    step = acc_r;
    for (int s = 0; s < hdlf_pkg::CONV_BITS; s++) begin
      for (int k = 0; k < hdlf_pkg::FULL_DIGITS; k++) begin
        if (step[4*k +: 4] >= 4'd5) step[4*k +: 4] = step[4*k +: 4] + 4'd3;
      end
      step = {step[hdlf_pkg::FULL_BCD_W-2:0], bin_r[hdlf_pkg::ADDR_W-1-s]};
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (clear) done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = bin;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bin_nxt = bin_r << hdlf_pkg::CONV_BITS;
      acc_nxt = step;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == hdlf_pkg::CONV_CNT_W'(hdlf_pkg::CONV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    acc_r <= acc_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign bcd         = acc_r[hdlf_pkg::DEC_W-1:0];

endmodule

`default_nettype wire

// ----- design/hdlf_line_fmt.sv -----
// ----------------------------------------------------------------------------
// hdlf_line_fmt
// Builds one hex dump text line from a block, its address and decimal address.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlf_line_fmt (
  input  wire hdlf_pkg::in_t                             item,
  input  wire logic [hdlf_pkg::ADDR_W-1:0]               addr,
  input  wire logic [hdlf_pkg::DEC_W-1:0]                dec,
  input  wire logic                                      hex_upper,
  output logic [hdlf_pkg::LINE_BUF_BYTES-1:0][7:0]       line,
  output logic [hdlf_pkg::LEN_W-1:0]                     len
);

  logic [hdlf_pkg::BYTES_PER_LINE-1:0][7:0] data;
  logic [4:0]                               n;

  assign data = {item.bytes_high, item.bytes_low};
  assign n    = (item.byte_count > 5'd16) ? 5'd16 : item.byte_count;
  assign len  = 7'd65 + {2'b00, n};

  always_comb begin
    line    = '0;
    line[0] = hdlf_pkg::CH_LBRACKET;
    for (int i = 0; i < hdlf_pkg::HEX_DIGITS; i++) begin
      line[1+i] = hdlf_pkg::hex_char(addr[4*(hdlf_pkg::HEX_DIGITS-1-i) +: 4], hex_upper);
    end
    line[11] = hdlf_pkg::CH_SPACE;
    for (int i = 0; i < hdlf_pkg::DEC_DIGITS; i++) begin
      line[12+i] = hdlf_pkg::CH_ZERO + {4'h0, dec[4*(hdlf_pkg::DEC_DIGITS-1-i) +: 4]};
    end
    line[23] = hdlf_pkg::CH_RBRACKET;
    for (int p = 24; p < 63; p++) begin
      line[p] = hdlf_pkg::CH_SPACE;
    end
    for (int i = 0; i < hdlf_pkg::BYTES_PER_LINE; i++) begin
      if (5'(i) < n) begin
        line[24+2*i+i/2] = hdlf_pkg::hex_char(data[i][7:4], hex_upper);
        line[25+2*i+i/2] = hdlf_pkg::hex_char(data[i][3:0], hex_upper);
      end
    end
    line[63] = hdlf_pkg::CH_BAR;
    for (int i = 0; i <= hdlf_pkg::BYTES_PER_LINE; i++) begin
      if (5'(i) < n) begin
        line[64+i] = hdlf_pkg::shown_char(data[i % hdlf_pkg::BYTES_PER_LINE]);
      end else if (5'(i) == n) begin
        line[64+i] = hdlf_pkg::CH_NEWLINE;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the hex dump line formatter.
// ----------------------------------------------------------------------------
// Every accepted block is formatted into its text line by a behavioral model
// in this file. The line is cut into 8-character words that wait in a queue.
// A receiver process checks each result word against the oldest queued word.
// Directed tests cover reset defaults, a range of byte counts and the
// printable limits. They also cover letter case and the wrap of the address,
// both binary and decimal. A random phase follows, made mostly of well-formed
// dump runs, with random idling on both sides. In a back-pressure test the
// receiver holds off for a long stretch while blocks keep arriving.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          CYCLE_LIMIT = 500000;
  localparam int          DRAIN_WAIT  = 16;
  localparam int          MAX_IDLE    = 16;
  localparam int          MAX_REPORTS = 10;
  localparam int          RANDOM_ITEMS = 130;
  localparam longint unsigned DEC_MODULUS = 64'd100000000000;
  localparam logic [hdlf_pkg::ADDR_W-1:0] ADDR_MAX = {hdlf_pkg::ADDR_W{1'b1}};

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  hdlf_pkg::in_t               in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  hdlf_pkg::out_t              out_data;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = hdlf_pkg::REG_START_ADDRESS;
  logic [hdlf_pkg::ADDR_W-1:0] cfg_wdata = '0;

  // model state and register copies
  logic [hdlf_pkg::ADDR_W-1:0] start_addr = '0;
  logic                        upper_hex = 1'b0;
  logic [hdlf_pkg::ADDR_W-1:0] line_addr = '0;

  hdlf_pkg::out_t expected_words[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  bit   send_idle = 1'b1;
  bit   recv_idle = 1'b1;
  int   hold_cycles = 0;

  hex_dump_line_formatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [7:0] nibble_text(input logic [3:0] nib);
    if (nib < 4'd10) return hdlf_pkg::CH_ZERO + 8'(nib);
    return (upper_hex ? 8'h41 : 8'h61) + 8'(nib - 4'd10);
  endfunction

  // Builds the text line of one block, queues its words, steps the address.
  task automatic predict_line(input hdlf_pkg::in_t blk);
    logic [7:0]      text [0:hdlf_pkg::LINE_BUF_BYTES-1];
    logic [127:0]    data;
    logic [7:0]      b;
    longint unsigned dec;
    int              n, pos, len, i, k, cnt;
    hdlf_pkg::out_t  word;
    n = (blk.byte_count > hdlf_pkg::BYTES_PER_LINE) ? hdlf_pkg::BYTES_PER_LINE
                                                     : int'(blk.byte_count);
    data = {blk.bytes_high, blk.bytes_low};
    if (blk.first_line) line_addr = start_addr;
    pos = 0;
    text[pos] = hdlf_pkg::CH_LBRACKET; pos++;
    for (i = hdlf_pkg::HEX_DIGITS - 1; i >= 0; i--) begin
      text[pos] = nibble_text(line_addr[4*i +: 4]); pos++;
    end
    text[pos] = hdlf_pkg::CH_SPACE; pos++;
    dec = 64'(line_addr) % DEC_MODULUS;
    for (i = hdlf_pkg::DEC_DIGITS - 1; i >= 0; i--) begin
      text[pos+i] = hdlf_pkg::CH_ZERO + 8'(dec % 10);
      dec = dec / 10;
    end
    pos = pos + hdlf_pkg::DEC_DIGITS;
    text[pos] = hdlf_pkg::CH_RBRACKET; pos++;
    for (i = 0; i < hdlf_pkg::BYTES_PER_LINE; i++) begin
      if (i != 0 && (i % 2) == 0) begin
        text[pos] = hdlf_pkg::CH_SPACE; pos++;
      end
      b = data[8*i +: 8];
      if (i < n) begin
        text[pos] = nibble_text(b[7:4]); pos++;
        text[pos] = nibble_text(b[3:0]); pos++;
      end else begin
        text[pos] = hdlf_pkg::CH_SPACE; pos++;
        text[pos] = hdlf_pkg::CH_SPACE; pos++;
      end
    end
    text[pos] = hdlf_pkg::CH_BAR; pos++;
    for (i = 0; i < n; i++) begin
      b = data[8*i +: 8];
      text[pos] = (b >= hdlf_pkg::CH_SPACE && b <= hdlf_pkg::CH_TILDE) ? b
                                                                       : hdlf_pkg::CH_DOT;
      pos++;
    end
    text[pos] = hdlf_pkg::CH_NEWLINE; pos++;
    len = pos;
    for (k = 0; 8 * k < len; k++) begin
      cnt = (len - 8 * k > 8) ? 8 : len - 8 * k;
      word = '0;
      for (i = 0; i < cnt; i++) word.text_chars[8*i +: 8] = text[8*k + i];
      word.char_count = 4'(cnt);
      word.line_end = (8 * k + 8 >= len);
      expected_words.push_back(word);
    end
    line_addr = line_addr + hdlf_pkg::ADDR_W'(hdlf_pkg::BYTES_PER_LINE);
  endtask

  function automatic hdlf_pkg::in_t rand_block(input int count, input bit first);
    hdlf_pkg::in_t blk;
    blk.bytes_low  = {$urandom, $urandom};
    blk.bytes_high = {$urandom, $urandom};
    blk.byte_count = 5'(count);
    blk.first_line = first;
    return blk;
  endfunction

  // Offers one block, after a random gap when send_idle is set, and waits for the transaction.
  task automatic send_block(input hdlf_pkg::in_t blk);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= blk;
    do @(posedge clk); while (in_stall);
    predict_line(blk);
  endtask

  task automatic write_reg(input logic idx, input logic [hdlf_pkg::ADDR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == hdlf_pkg::REG_START_ADDRESS) start_addr = value;
    else upper_hex = value[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // result side: random stall when recv_idle is set, optional long hold, then check one transaction
  initial begin
    int             n;
    hdlf_pkg::out_t exp_word;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      n = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_words.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("ERROR: unexpected result text=%h count=%0d end=%b",
                   out_data.text_chars, out_data.char_count, out_data.line_end);
        mismatch_count++;
      end else begin
        exp_word = expected_words.pop_front();
        if (out_data.text_chars !== exp_word.text_chars ||
            out_data.char_count !== exp_word.char_count ||
            out_data.line_end !== exp_word.line_end) begin
          if (mismatch_count < MAX_REPORTS)
            $display("ERROR: text exp=%h act=%h count exp=%0d act=%0d end exp=%b act=%b",
                     exp_word.text_chars, out_data.text_chars,
                     exp_word.char_count, out_data.char_count,
                     exp_word.line_end, out_data.line_end);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_block(rand_block(16, 1'b0));
    send_block(rand_block(16, 1'b0));
    wait_idle();
  endtask

  task automatic test_byte_counts();
    hdlf_pkg::in_t blk;
    blk = '0;
    blk.byte_count = 5'd0;
    blk.first_line = 1'b1;
    send_block(blk);
    blk.bytes_low  = '1;
    blk.bytes_high = '1;
    blk.byte_count = 5'd1;
    blk.first_line = 1'b0;
    send_block(blk);
    blk.bytes_low  = 64'h7F7E_201F_8000_FF00;
    blk.bytes_high = 64'h4142_617A_7E7F_2019;
    blk.byte_count = 5'd16;
    send_block(blk);
    blk.byte_count = 5'd15;
    send_block(blk);
    blk.byte_count = 5'd17;
    send_block(blk);
    blk.byte_count = 5'd31;
    send_block(blk);
    send_block(rand_block(8, 1'b1));
    send_block(rand_block(9, 1'b0));
    wait_idle();
  endtask

  task automatic test_hex_case();
    write_reg(hdlf_pkg::REG_START_ADDRESS, 40'hAB_CDEF_ABC0);
    write_reg(hdlf_pkg::REG_HEX_UPPER, hdlf_pkg::ADDR_W'({$urandom, $urandom}) | 40'h1);
    send_block(rand_block(16, 1'b1));
    send_block(rand_block(12, 1'b0));
    wait_idle();
    write_reg(hdlf_pkg::REG_HEX_UPPER, hdlf_pkg::ADDR_W'({$urandom, $urandom}) & ~40'h1);
    send_block(rand_block(16, 1'b0));
    wait_idle();
  endtask

  task automatic test_address_wrap();
    int i;
    write_reg(hdlf_pkg::REG_START_ADDRESS, ADDR_MAX - 40'd47);
    for (i = 0; i < 4; i++) send_block(rand_block(16, i == 0));
    wait_idle();
    write_reg(hdlf_pkg::REG_START_ADDRESS, 40'(DEC_MODULUS - 64'd24));
    for (i = 0; i < 3; i++) send_block(rand_block(16, i == 0));
    wait_idle();
    write_reg(hdlf_pkg::REG_START_ADDRESS, ADDR_MAX);
    send_block(rand_block(16, 1'b1));
    send_block(rand_block(16, 1'b0));
    wait_idle();
    write_reg(hdlf_pkg::REG_START_ADDRESS, '0);
    send_block(rand_block(3, 1'b1));
    wait_idle();
  endtask

  task automatic test_random_dumps();
    int sent, run_len, i, sel;
    logic [hdlf_pkg::ADDR_W-1:0] addr;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      sel = $urandom_range(0, 7);
      case (sel)
        0: addr = '0;
        1: addr = ADDR_MAX - 40'(16 * $urandom_range(0, 6));
        2: addr = 40'(DEC_MODULUS - 64'(16 * $urandom_range(1, 6)));
        default: addr = hdlf_pkg::ADDR_W'({$urandom, $urandom});
      endcase
      write_reg(hdlf_pkg::REG_START_ADDRESS, addr);
      write_reg(hdlf_pkg::REG_HEX_UPPER, hdlf_pkg::ADDR_W'({$urandom, $urandom}));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      for (int p = 0; p < 4; p++) begin
        if ($urandom_range(0, 99) < 85) begin
          run_len = $urandom_range(1, 10);
          for (i = 0; i < run_len; i++)
            send_block(rand_block((i == run_len - 1) ? $urandom_range(1, 16) : 16, i == 0));
          sent = sent + run_len;
        end else begin
          send_block(rand_block($urandom_range(0, 31), 1'($urandom_range(0, 1))));
          sent++;
        end
      end
    end
    wait_idle();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    int i;
    send_idle = 1'b0;
    hold_cycles = 400;
    for (i = 0; i < 20; i++) send_block(rand_block(16, i == 0));
    wait_idle();
    send_idle = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_byte_counts();
    test_hex_case();
    test_address_wrap();
    test_random_dumps();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- hex_dump_line_formatter.f -----
design/hdlf_pkg.sv
design/hdlf_bcd_conv.sv
design/hdlf_line_fmt.sv
design/hex_dump_line_formatter.sv
tb/tb_top.sv
